### rtl/sample_playback_voice_defines.svh
// Assertion macros for the sample playback voice.
// Included by the modules that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef SAMPLE_PLAYBACK_VOICE_DEFINES_SVH
`define SAMPLE_PLAYBACK_VOICE_DEFINES_SVH
`ifndef SYNTHESIS
// General property check, disabled while reset is asserted.
`define SPV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Same-cycle implication check, disabled while reset is asserted.
`define SPV_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) else $error(msg);
`else
`define SPV_ASSERT(lbl, prop, msg)
`define SPV_ASSERT_IMPL(lbl, pre, post, msg)
`endif
`endif

### rtl/spv_pkg.sv
// Shared types, widths, codes and helper functions for the sample playback voice.
// No dependencies; imported by the interfaces, the lane, the top level and the testbench.
package spv_pkg;

    // Default parameter values. The sample memory depth must be a power of two.
    localparam int SAMPLE_DEPTH_DEF = 65536;
    localparam int SAMPLE_BITS_DEF  = 16;

    // Field widths of the transaction payloads.
    localparam int MODE_W   = 3;
    localparam int ADDR_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int ENV_W    = 24;
    localparam int MIX_W    = 24;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SRC_STEREO = 2'd0;
    localparam t_cfg_idx CFG_OUT_STEREO = 2'd1;
    localparam t_cfg_idx CFG_LENGTH     = 2'd2;

    // Operation codes carried in the mode field.
    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_LOAD     = 3'd0;
    localparam t_mode MODE_START    = 3'd1;
    localparam t_mode MODE_RELEASE  = 3'd2;
    localparam t_mode MODE_STOP     = 3'd3;
    localparam t_mode MODE_TICK     = 3'd4;

    // Tick sequencer states; the lanes follow the same codes.
    typedef logic [2:0] t_step;
    localparam t_step ST_IDLE = 3'd0;  // waiting for a transaction
    localparam t_step ST_A    = 3'd1;  // first frame arrives, second frame read issued
    localparam t_step ST_B    = 3'd2;  // second frame arrives, interpolation multiply
    localparam t_step ST_G    = 3'd3;  // velocity gain multiply
    localparam t_step ST_E    = 3'd4;  // envelope multiply
    localparam t_step ST_M    = 3'd5;  // mix, saturate, update voice state

    // Fixed-point scaling: gain is Q1.15, envelope is Q1.23.
    localparam int GAIN_SHIFT = 15;
    localparam int ENV_SHIFT  = ENV_W - 1;
    localparam logic [ENV_W-1:0] UNITY23 = 24'h800000;

    localparam logic signed [MIX_W-1:0] MIX_MAX = 24'sh7FFFFF;
    localparam logic signed [MIX_W-1:0] MIX_MIN = -24'sh800000;

    // Operands handed from the sequencer to each interpolation lane.
    typedef struct packed {
        t_step             step;
        logic [FRAC_W-1:0] frac;
        logic [GAIN_W-1:0] gain;
        logic [ENV_W-1:0]  level;
    } t_lane_ctrl;

    // Signed width of an intermediate sample value, with headroom for the gain.
    function automatic int value_width(input int sample_bits);
        return 44 - sample_bits;
    endfunction

endpackage

### rtl/spv_in_if.sv
// Input channel of the sample playback voice: valid/ready handshake plus item fields.
// Depends on spv_pkg for the field widths.
interface spv_in_if import spv_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic [ADDR_W-1:0]          address;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
    logic [PHASE_W-1:0]         phase_step;
    logic [GAIN_W-1:0]          velocity;
    logic [ENV_W-1:0]           attack_step;
    logic [ENV_W-1:0]           release_step;
    logic signed [MIX_W-1:0]    mix_left;
    logic signed [MIX_W-1:0]    mix_right;

    modport source (
        output valid, mode, address, sample_left, sample_right, phase_step,
               velocity, attack_step, release_step, mix_left, mix_right,
        input  ready
    );
    modport sink (
        input  valid, mode, address, sample_left, sample_right, phase_step,
               velocity, attack_step, release_step, mix_left, mix_right,
        output ready
    );
endinterface

### rtl/spv_out_if.sv
// Result channel of the sample playback voice: valid/ready handshake plus result fields.
// Depends on spv_pkg for the field widths.
interface spv_out_if import spv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [MIX_W-1:0] out_left;
    logic signed [MIX_W-1:0] out_right;
    logic                    voice_active;
    logic                    note_ended;

    modport source (
        output valid, out_left, out_right, voice_active, note_ended,
        input  ready
    );
    modport sink (
        input  valid, out_left, out_right, voice_active, note_ended,
        output ready
    );
endinterface

### rtl/spv_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module spv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read both happen on the clock edge; read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/spv_lane.sv
// One channel of the voice datapath: interpolation, gain and envelope on one multiplier.
// Depends on spv_pkg; sequenced by the top level through a t_lane_ctrl struct.
module spv_lane import spv_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                       i_clk,
    input  t_lane_ctrl                                 i_ctrl,
    input  logic signed [SAMPLE_W-1:0]                 i_sample,
    output logic signed [value_width(SAMPLE_BITS)-1:0] o_value
);

    localparam int OPA_W     = value_width(SAMPLE_BITS);
    localparam int OPB_W     = ENV_W + 1;
    localparam int PROD_W    = OPA_W + OPB_W;
    localparam int INT_SHIFT = SAMPLE_BITS - 8;

    // Rounding offsets: half of one output LSB for each scaling step.
    localparam logic signed [PROD_W-1:0] INT_HALF  = (PROD_W'(1) << INT_SHIFT) >> 1;
    localparam logic signed [PROD_W-1:0] GAIN_HALF = PROD_W'(1) << (GAIN_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] ENV_HALF  = PROD_W'(1) << (ENV_SHIFT - 1);

    logic signed [SAMPLE_W-1:0] r_first;
    logic signed [PROD_W-1:0]   r_prod;

    logic signed [SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]   interp_sum;
    logic signed [PROD_W-1:0]   int_round;
    logic signed [PROD_W-1:0]   gain_round;
    logic signed [PROD_W-1:0]   env_round;
    logic signed [OPA_W-1:0]    op_a;
    logic signed [OPB_W-1:0]    op_b;
    logic signed [PROD_W-1:0]   product;

    // Interpolation is a*2^16 + (b-a)*f; each scaled result is rounded to nearest, ties up.
    always_comb begin
        diff       = (SAMPLE_W+1)'(i_sample) - (SAMPLE_W+1)'(r_first);
        interp_sum = (PROD_W'(r_first) <<< FRAC_W) + r_prod;
        int_round  = (interp_sum + INT_HALF) >>> INT_SHIFT;
        gain_round = (r_prod + GAIN_HALF) >>> GAIN_SHIFT;
        env_round  = (r_prod + ENV_HALF) >>> ENV_SHIFT;
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_ctrl.step)
            ST_B: begin
                op_a = OPA_W'(diff);
                op_b = OPB_W'(i_ctrl.frac);
            end
            ST_G: begin
                op_a = OPA_W'(int_round);
                op_b = OPB_W'(i_ctrl.gain);
            end
            default: begin
                op_a = OPA_W'(gain_round);
                op_b = OPB_W'(i_ctrl.level);
            end
        endcase
        product = op_a * op_b;
    end

    // Hold the first frame, then register each product.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step == ST_A) begin
            r_first <= i_sample;
        end
        if (i_ctrl.step == ST_B || i_ctrl.step == ST_G || i_ctrl.step == ST_E) begin
            r_prod <= product;
        end
    end

    assign o_value = OPA_W'(env_round);

endmodule

### rtl/sample_playback_voice.sv
// A tick goes from acceptance to a result in the output register in these steps: reading the
// neighboring frames from the single read port of the sample memory, then one multiply each
// for interpolation, velocity gain and envelope in each channel lane, and a mix step that
// saturates, updates the voice and waits while the output register is full. Loads, note starts,
// releases and stops return no result; they are accepted even while a tick result waits to be
// taken. The sample memory is not cleared: software loads sample_length+2 frames before a
// note starts. SAMPLE_DEPTH must be a power of two. Configuration writes are taken at any time.
`include "sample_playback_voice_defines.svh"

module sample_playback_voice import spv_pkg::*; #(
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    spv_in_if.sink                i_req,
    spv_out_if.source             o_rsp
);

    localparam int AW    = $clog2(SAMPLE_DEPTH);
    localparam int VAL_W = value_width(SAMPLE_BITS);
    localparam int SUM_W = ((VAL_W > MIX_W) ? VAL_W : MIX_W) + 2;
    localparam int RAM_W = 2 * SAMPLE_W;

    // Sequencer and configuration.
    t_step                 r_state;
    t_step                 n_state;
    logic                  r_src_stereo;
    logic                  r_out_stereo;
    logic [FRAC_W-1:0]     r_len;

    // Voice state.
    logic [PHASE_W-1:0]    r_pos;
    logic [PHASE_W-1:0]    r_step;
    logic [GAIN_W-1:0]     r_gain;
    logic [ENV_W-1:0]      r_level;
    logic [ENV_W-1:0]      r_rise;
    logic [ENV_W-1:0]      r_fall;
    logic                  r_in_attack;
    logic                  r_in_release;
    logic                  r_playing;

    // Tick operands and output register.
    logic signed [MIX_W-1:0] r_mix_l;
    logic signed [MIX_W-1:0] r_mix_r;
    logic                    r_out_valid;
    logic signed [MIX_W-1:0] r_out_left;
    logic signed [MIX_W-1:0] r_out_right;
    logic                    r_out_active;
    logic                    r_out_ended;

    logic                    req_accept;
    logic                    out_free;
    logic                    finish;
    logic [AW-1:0]           idx0;
    logic [AW-1:0]           raddr;
    logic                    mem_we;
    logic [RAM_W-1:0]        rdata;
    logic signed [SAMPLE_W-1:0] smp_l;
    logic signed [SAMPLE_W-1:0] smp_r;
    t_lane_ctrl              lane_ctrl;
    logic signed [VAL_W-1:0] val_l;
    logic signed [VAL_W-1:0] val_r;
    logic signed [SUM_W-1:0] sum_l;
    logic signed [SUM_W-1:0] sum_r;
    logic signed [SUM_W-1:0] sum_mono;
    logic                    rel_end;
    logic [ENV_W:0]          att_level;
    logic                    att_done;
    logic [PHASE_W:0]        new_pos;
    logic                    pos_end;

    function automatic logic signed [MIX_W-1:0] sat_mix(input logic signed [SUM_W-1:0] x);
        if (x > SUM_W'(MIX_MAX)) begin
            return MIX_MAX;
        end else if (x < SUM_W'(MIX_MIN)) begin
            return MIX_MIN;
        end
        return MIX_W'(x);
    endfunction

    // Handshakes: items enter only while the sequencer is idle.
    assign i_req.ready = (r_state == ST_IDLE);
    assign req_accept  = i_req.valid & i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign finish      = (r_state == ST_M) && out_free;

    // Sample memory: loads write, ticks read frame i and then frame i+1.
    assign idx0   = AW'(r_pos[PHASE_W-1:FRAC_W]);
    assign raddr  = (r_state == ST_A) ? idx0 + AW'(1) : idx0;
    assign mem_we = req_accept && (i_req.mode == MODE_LOAD);

    spv_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(i_req.address)),
        .i_wdata ({i_req.sample_left, i_req.sample_right}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // A mono source feeds the left frame to both lanes.
    assign smp_l = rdata[RAM_W-1:SAMPLE_W];
    assign smp_r = r_src_stereo ? rdata[SAMPLE_W-1:0] : smp_l;

    // Outside attack and release the envelope multiply is by unity.
    always_comb begin
        lane_ctrl.step  = r_state;
        lane_ctrl.frac  = r_pos[FRAC_W-1:0];
        lane_ctrl.gain  = r_gain;
        lane_ctrl.level = (r_in_attack || r_in_release) ? r_level : UNITY23;
    end

    spv_lane #(.SAMPLE_BITS (SAMPLE_BITS)) u_lane_l (
        .i_clk    (i_clk),
        .i_ctrl   (lane_ctrl),
        .i_sample (smp_l),
        .o_value  (val_l)
    );

    spv_lane #(.SAMPLE_BITS (SAMPLE_BITS)) u_lane_r (
        .i_clk    (i_clk),
        .i_ctrl   (lane_ctrl),
        .i_sample (smp_r),
        .o_value  (val_r)
    );

    // Mix sums, envelope steps and end-of-sample detection.
    always_comb begin
        sum_l     = SUM_W'(r_mix_l) + SUM_W'(val_l);
        sum_r     = SUM_W'(r_mix_r) + SUM_W'(val_r);
        sum_mono  = SUM_W'(r_mix_l) + ((SUM_W'(val_l) + SUM_W'(val_r)) >>> 1);
        rel_end   = r_in_release && (r_fall >= r_level);
        att_level = {1'b0, r_level} + {1'b0, r_rise};
        att_done  = att_level >= {1'b0, UNITY23};
        new_pos   = {1'b0, r_pos} + {1'b0, r_step};
        pos_end   = new_pos > {1'b0, r_len, {FRAC_W{1'b0}}};
    end

    // Tick sequencer.
    always_comb begin
        case (r_state)
            ST_IDLE: n_state = (req_accept && i_req.mode == MODE_TICK) ? ST_A : ST_IDLE;
            ST_A:    n_state = ST_B;
            ST_B:    n_state = ST_G;
            ST_G:    n_state = ST_E;
            ST_E:    n_state = ST_M;
            ST_M:    n_state = out_free ? ST_IDLE : ST_M;
            default: n_state = ST_IDLE;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_stereo <= 1'b1;
            r_out_stereo <= 1'b1;
            r_len        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SRC_STEREO: r_src_stereo <= i_cfg_data[0];
                CFG_OUT_STEREO: r_out_stereo <= i_cfg_data[0];
                CFG_LENGTH:     r_len        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Tick operands are captured when the tick transaction is accepted.
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_mix_l <= i_req.mix_left;
            r_mix_r <= i_req.mix_right;
        end
    end

    // Voice state: note commands in idle, per-tick updates when the result is stored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pos        <= '0;
            r_step       <= '0;
            r_gain       <= '0;
            r_level      <= '0;
            r_rise       <= '0;
            r_fall       <= UNITY23;
            r_in_attack  <= 1'b0;
            r_in_release <= 1'b0;
            r_playing    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (req_accept) begin
                case (i_req.mode)
                    MODE_START: begin
                        r_pos        <= '0;
                        r_step       <= i_req.phase_step;
                        r_gain       <= i_req.velocity;
                        r_rise       <= i_req.attack_step;
                        r_in_attack  <= (i_req.attack_step != '0);
                        r_in_release <= 1'b0;
                        r_level      <= (i_req.attack_step != '0) ? '0 : UNITY23;
                        r_fall       <= (i_req.release_step != '0) ? i_req.release_step
                                                                    : UNITY23;
                        r_playing    <= 1'b1;
                    end
                    MODE_RELEASE: begin
                        if (r_playing) begin
                            r_in_attack  <= 1'b0;
                            r_in_release <= 1'b1;
                        end
                    end
                    MODE_STOP: begin
                        r_playing    <= 1'b0;
                        r_in_attack  <= 1'b0;
                        r_in_release <= 1'b0;
                    end
                    default: ;
                endcase
            end else if (finish && r_playing) begin
                if (rel_end) begin
                    r_level      <= '0;
                    r_playing    <= 1'b0;
                    r_in_release <= 1'b0;
                end else begin
                    if (r_in_attack) begin
                        r_level <= att_done ? UNITY23 : att_level[ENV_W-1:0];
                        if (att_done) begin
                            r_in_attack <= 1'b0;
                        end
                    end else if (r_in_release) begin
                        r_level <= r_level - r_fall;
                    end
                    r_pos <= new_pos[PHASE_W-1:0];
                    if (pos_end) begin
                        r_playing    <= 1'b0;
                        r_in_attack  <= 1'b0;
                        r_in_release <= 1'b0;
                    end
                end
            end
        end
    end

    // Output register: valid control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: result fields.
    always_ff @(posedge i_clk) begin
        if (finish) begin
            if (!r_playing || rel_end) begin
                r_out_left   <= r_mix_l;
                r_out_right  <= r_mix_r;
                r_out_active <= 1'b0;
                r_out_ended  <= r_playing;
            end else begin
                r_out_left   <= r_out_stereo ? sat_mix(sum_l) : sat_mix(sum_mono);
                r_out_right  <= r_out_stereo ? sat_mix(sum_r) : r_mix_r;
                r_out_active <= !pos_end;
                r_out_ended  <= pos_end;
            end
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.out_left     = r_out_left;
    assign o_rsp.out_right    = r_out_right;
    assign o_rsp.voice_active = r_out_active;
    assign o_rsp.note_ended   = r_out_ended;

    // Checks on the sequencer and the voice state.
    `SPV_ASSERT(a_tick_latency, (req_accept && i_req.mode == MODE_TICK) |-> ##5 (r_state == ST_M), "tick did not reach the mix step in five cycles")
    `SPV_ASSERT(a_level_range, r_level <= UNITY23, "envelope level above unity")
    `SPV_ASSERT_IMPL(a_idle_flags, !r_playing, !r_in_attack && !r_in_release, "envelope phase set while the voice is silent")
    `SPV_ASSERT_IMPL(a_one_phase, r_in_attack, !r_in_release, "attack and release both set")
    `SPV_ASSERT_IMPL(a_end_inactive, r_out_valid && r_out_ended, !r_out_active, "ended note reported as still active")

endmodule

### test/tb_sample_playback_voice.sv
// Self-checking testbench for the sample playback voice: loads, notes, stops and mix ticks.
// Depends on spv_pkg, spv_in_if, spv_out_if and sample_playback_voice from the RTL.
module tb_sample_playback_voice;
    import spv_pkg::*;

    // One input transaction and one tick result, at the block's field widths.
    typedef struct {
        t_mode                      mode;
        logic [ADDR_W-1:0]          address;
        logic signed [SAMPLE_W-1:0] sample_left;
        logic signed [SAMPLE_W-1:0] sample_right;
        logic [PHASE_W-1:0]         phase_step;
        logic [GAIN_W-1:0]          velocity;
        logic [ENV_W-1:0]           attack_step;
        logic [ENV_W-1:0]           release_step;
        logic signed [MIX_W-1:0]    mix_left;
        logic signed [MIX_W-1:0]    mix_right;
    } voice_req_t;

    typedef struct {
        logic signed [MIX_W-1:0] out_left;
        logic signed [MIX_W-1:0] out_right;
        logic                    voice_active;
        logic                    note_ended;
    } mix_out_t;

    // Voice state; the level keeps one bit of headroom for the attack sum.
    typedef struct {
        logic [PHASE_W-1:0] pos;
        logic [PHASE_W-1:0] step;
        logic [GAIN_W-1:0]  gain;
        logic [ENV_W:0]     level;
        logic [ENV_W-1:0]   rise;
        logic [ENV_W-1:0]   fall;
        bit                 attacking;
        bit                 releasing;
        bit                 playing;
    } voice_state_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    spv_in_if  req_if ();
    spv_out_if rsp_if ();

    sample_playback_voice dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source)
    );

    // Predictor state at acceptance, and a copy that runs ahead while stimulus is built.
    voice_state_t               voice;
    voice_state_t               gen_voice;
    logic signed [SAMPLE_W-1:0] left_mem  [SAMPLE_DEPTH_DEF];
    logic signed [SAMPLE_W-1:0] right_mem [SAMPLE_DEPTH_DEF];
    bit                         frame_loaded [SAMPLE_DEPTH_DEF];
    bit                         src_stereo = 1'b1;
    bit                         out_stereo = 1'b1;
    logic [15:0]                length_cfg = 16'd0;

    voice_req_t  voice_req_q[$];
    mix_out_t    expected_mix_q[$];
    voice_req_t  cur_req;
    int unsigned outstanding;
    int unsigned useful_items;
    int unsigned accepted_items;
    int unsigned results_seen;
    int unsigned notes_ended;
    int unsigned errors;
    int unsigned send_gap;
    int unsigned recv_gap;
    int unsigned hold_left;
    logic        hold_arm;
    bit          calm;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #2000000;
        $display("Timed out with %0d transactions and %0d results outstanding",
                 outstanding, expected_mix_q.size());
        $display("TEST FAILED");
        $finish;
    end

    // floor(x / 2^s + 1/2) for s > 0.
    function automatic longint round_shift(longint x, int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [MIX_W-1:0] sat_mix(longint x);
        if (x > longint'(MIX_MAX))
            return MIX_MAX;
        if (x < longint'(MIX_MIN))
            return MIX_MIN;
        return x[MIX_W-1:0];
    endfunction

    // Linear interpolation between two frames, scaled to 24 bits.
    function automatic longint interp_frames(longint a, longint b, logic [FRAC_W-1:0] frac);
        longint f;
        f = frac;
        return round_shift(a * (65536 - f) + b * f, SAMPLE_BITS_DEF - 8);
    endfunction

    // Voice state update for one transaction; the tick's sample is dropped when release ends.
    function automatic void advance_voice(inout voice_state_t v, input voice_req_t r,
                                          input logic [15:0] len, output bit ended,
                                          output bit dropped);
        logic [PHASE_W:0] next_pos;
        ended   = 1'b0;
        dropped = 1'b0;
        case (r.mode)
            MODE_START: begin
                v.pos       = '0;
                v.step      = r.phase_step;
                v.gain      = r.velocity;
                v.attacking = (r.attack_step != 0);
                v.releasing = 1'b0;
                v.rise      = r.attack_step;
                if (r.attack_step != 0)
                    v.level = '0;
                else
                    v.level = UNITY23;
                if (r.release_step != 0)
                    v.fall = r.release_step;
                else
                    v.fall = UNITY23;
                v.playing = 1'b1;
            end
            MODE_RELEASE: begin
                if (v.playing) begin
                    v.attacking = 1'b0;
                    v.releasing = 1'b1;
                end
            end
            MODE_STOP: begin
                v.playing   = 1'b0;
                v.attacking = 1'b0;
                v.releasing = 1'b0;
            end
            MODE_TICK: begin
                if (v.playing) begin
                    if (v.attacking) begin
                        v.level = v.level + v.rise;
                        if (v.level >= UNITY23) begin
                            v.level     = UNITY23;
                            v.attacking = 1'b0;
                        end
                    end else if (v.releasing) begin
                        if (v.fall >= v.level) begin
                            v.level     = '0;
                            v.playing   = 1'b0;
                            v.releasing = 1'b0;
                            ended       = 1'b1;
                            dropped     = 1'b1;
                        end else begin
                            v.level = v.level - v.fall;
                        end
                    end
                    if (!dropped) begin
                        next_pos = {1'b0, v.pos} + v.step;
                        v.pos    = next_pos[PHASE_W-1:0];
                        // The 33-bit sum also catches a carry out of the position.
                        if (next_pos > {len, 16'h0000}) begin
                            v.playing   = 1'b0;
                            v.attacking = 1'b0;
                            v.releasing = 1'b0;
                            ended       = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Mix result of a tick, from the voice state as it was before the tick.
    function automatic mix_out_t predict_mix(voice_state_t v, voice_req_t r, bit active,
                                             bit ended, bit dropped);
        mix_out_t          o;
        longint            l;
        longint            rr;
        logic [ADDR_W-1:0] i0;
        logic [ADDR_W-1:0] i1;
        o.out_left     = r.mix_left;
        o.out_right    = r.mix_right;
        o.voice_active = active;
        o.note_ended   = ended;
        if (!v.playing || dropped)
            return o;
        i0 = v.pos[31:16];
        i1 = i0 + 1'b1;
        l  = interp_frames(longint'(left_mem[i0]), longint'(left_mem[i1]), v.pos[15:0]);
        if (src_stereo)
            rr = interp_frames(longint'(right_mem[i0]), longint'(right_mem[i1]), v.pos[15:0]);
        else
            rr = l;
        l  = round_shift(l * longint'(v.gain), GAIN_SHIFT);
        rr = round_shift(rr * longint'(v.gain), GAIN_SHIFT);
        if (v.attacking || v.releasing) begin
            l  = round_shift(l * longint'(v.level), ENV_SHIFT);
            rr = round_shift(rr * longint'(v.level), ENV_SHIFT);
        end
        if (out_stereo) begin
            o.out_left  = sat_mix(longint'(r.mix_left) + l);
            o.out_right = sat_mix(longint'(r.mix_right) + rr);
        end else begin
            o.out_left = sat_mix(longint'(r.mix_left) + ((l + rr) >>> 1));
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("Mismatch at result %0d, %s: got %0d, expected %0d",
                 results_seen, what, got, want);
        errors++;
    endtask

    // Apply an accepted transaction to the predictor.
    task automatic accept_item(voice_req_t r);
        voice_state_t prior;
        bit           ended;
        bit           dropped;
        prior = voice;
        if (r.mode == MODE_LOAD) begin
            left_mem[r.address]  = r.sample_left;
            right_mem[r.address] = r.sample_right;
        end
        advance_voice(voice, r, length_cfg, ended, dropped);
        if (r.mode == MODE_TICK)
            expected_mix_q.push_back(predict_mix(prior, r, voice.playing, ended, dropped));
        accepted_items++;
        outstanding--;
    endtask

    task automatic check_result();
        mix_out_t want;
        if (expected_mix_q.size() == 0) begin
            report_mismatch("result with no tick pending", rsp_if.out_left, 0);
        end else begin
            want = expected_mix_q.pop_front();
            results_seen++;
            if (rsp_if.out_left !== want.out_left)
                report_mismatch("out_left", rsp_if.out_left, want.out_left);
            if (rsp_if.out_right !== want.out_right)
                report_mismatch("out_right", rsp_if.out_right, want.out_right);
            if (rsp_if.voice_active !== want.voice_active)
                report_mismatch("voice_active", rsp_if.voice_active, want.voice_active);
            if (rsp_if.note_ended !== want.note_ended)
                report_mismatch("note_ended", rsp_if.note_ended, want.note_ended);
            if (want.note_ended)
                notes_ended++;
        end
    endtask

    // Driver: presents queued transactions, with short random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_gap     <= 0;
        end else begin
            if (req_if.valid && req_if.ready)
                accept_item(cur_req);
            if (!req_if.valid || req_if.ready) begin
                if (send_gap != 0) begin
                    send_gap     <= send_gap - 1;
                    req_if.valid <= 1'b0;
                end else if (voice_req_q.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
                    send_gap     <= $urandom_range(0, 2);
                    req_if.valid <= 1'b0;
                end else if (voice_req_q.size() != 0) begin
                    cur_req              = voice_req_q.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.mode         <= cur_req.mode;
                    req_if.address      <= cur_req.address;
                    req_if.sample_left  <= cur_req.sample_left;
                    req_if.sample_right <= cur_req.sample_right;
                    req_if.phase_step   <= cur_req.phase_step;
                    req_if.velocity     <= cur_req.velocity;
                    req_if.attack_step  <= cur_req.attack_step;
                    req_if.release_step <= cur_req.release_step;
                    req_if.mix_left     <= cur_req.mix_left;
                    req_if.mix_right    <= cur_req.mix_right;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down on its own.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_arm)
            hold_left <= 90;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: checks each result transaction and stalls the result channel at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            recv_gap     <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready)
                check_result();
            if (hold_left != 0) begin
                rsp_if.ready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap     <= recv_gap - 1;
                rsp_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                recv_gap     <= $urandom_range(0, 2);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Random field values, biased toward the edges.
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [MIX_W-1:0] rand_mix();
        case ($urandom_range(0, 3))
            0: return MIX_MAX - $urandom_range(0, 4000);
            1: return MIX_MIN + $urandom_range(0, 4000);
            2: return $urandom_range(0, 20000) - 10000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PHASE_W-1:0] rand_step();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            3, 4: return $urandom_range(1, 32'hFFFF);
            default: return $urandom_range(32'h8000, 32'h30000);
        endcase
    endfunction

    function automatic voice_req_t rand_req(t_mode m);
        voice_req_t r;
        r.mode         = m;
        r.address      = $urandom;
        r.sample_left  = rand_sample();
        r.sample_right = rand_sample();
        r.phase_step   = $urandom;
        r.velocity     = $urandom_range(0, 32768);
        r.attack_step  = $urandom_range(0, UNITY23);
        r.release_step = $urandom_range(1, UNITY23);
        r.mix_left     = rand_mix();
        r.mix_right    = rand_mix();
        return r;
    endfunction

    // Queue one transaction and advance the look-ahead voice.
    task automatic queue_item(voice_req_t r);
        bit ended;
        bit dropped;
        if (r.mode == MODE_LOAD)
            frame_loaded[r.address] = 1'b1;
        if (r.mode == MODE_LOAD || r.mode == MODE_START || r.mode == MODE_STOP ||
            r.mode == MODE_TICK || (r.mode == MODE_RELEASE && gen_voice.playing))
            useful_items++;
        advance_voice(gen_voice, r, length_cfg, ended, dropped);
        voice_req_q.push_back(r);
        outstanding++;
    endtask

    // A tick never reads a frame that has not been loaded; missing frames are loaded first.
    task automatic queue_tick(voice_req_t r);
        voice_req_t        fill;
        logic [ADDR_W-1:0] spot;
        if (gen_voice.playing) begin
            spot = gen_voice.pos[31:16];
            repeat (2) begin
                if (!frame_loaded[spot]) begin
                    fill         = rand_req(MODE_LOAD);
                    fill.address = spot;
                    queue_item(fill);
                end
                spot = spot + 1'b1;
            end
        end
        queue_item(r);
    endtask

    // A well-formed note: start, some ticks, then a release, a hard stop, or neither.
    task automatic play_note();
        voice_req_t r;
        int         n;
        r            = rand_req(MODE_START);
        r.phase_step = rand_step();
        case ($urandom_range(0, 3))
            0: r.velocity = 16'h8000;
            1: r.velocity = $urandom_range(0, 255);
            default: r.velocity = $urandom_range(0, 32768);
        endcase
        case ($urandom_range(0, 3))
            0: r.attack_step = '0;
            1: r.attack_step = UNITY23;
            2: r.attack_step = UNITY23 / $urandom_range(2, 16);
            default: r.attack_step = $urandom_range(1, 1 << 20);
        endcase
        case ($urandom_range(0, 3))
            0: r.release_step = UNITY23;
            1: r.release_step = $urandom_range(1, UNITY23);
            default: r.release_step = UNITY23 / $urandom_range(2, 12);
        endcase
        queue_item(r);
        repeat ($urandom_range(1, 20))
            queue_tick(rand_req(MODE_TICK));
        case ($urandom_range(0, 3))
            0: queue_item(rand_req(MODE_STOP));
            1, 2: begin
                queue_item(rand_req(MODE_RELEASE));
                n = 0;
                while (gen_voice.playing && n < 30) begin
                    queue_tick(rand_req(MODE_TICK));
                    n++;
                end
                if (gen_voice.playing)
                    queue_item(rand_req(MODE_STOP));
            end
            default: ;
        endcase
    endtask

    // Mostly notes, with stray transactions of every mode in between.
    task automatic random_items(int unsigned budget);
        int unsigned stop_at;
        t_mode       m;
        stop_at = useful_items + budget;
        while (useful_items < stop_at) begin
            case ($urandom_range(0, 9))
                0: begin
                    m = $urandom_range(0, 7);
                    if (m == MODE_TICK)
                        queue_tick(rand_req(MODE_TICK));
                    else
                        queue_item(rand_req(m));
                end
                1: queue_tick(rand_req(MODE_TICK));
                default: play_note();
            endcase
        end
    endtask

    // Wait until every transaction is taken and every result checked, then let the block settle.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (outstanding != 0 || expected_mix_q.size() != 0);
        repeat (10) @(posedge i_clk);
    endtask

    // Register writes, only while the block is idle; the 1-bit registers get noise above bit 0.
    task automatic write_config(bit src, bit outs, logic [15:0] len);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SRC_STEREO;
        cfg_data  <= {15'($urandom), src};
        @(posedge i_clk);
        cfg_index <= CFG_OUT_STEREO;
        cfg_data  <= {15'($urandom), outs};
        @(posedge i_clk);
        cfg_index <= CFG_LENGTH;
        cfg_data  <= len;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        src_stereo  = src;
        out_stereo  = outs;
        length_cfg  = len;
    endtask

    task automatic run_phase(bit src, bit outs, logic [15:0] len, int unsigned budget);
        write_config(src, outs, len);
        random_items(budget);
        wait_drained();
    endtask

    // Directed opening: edge samples, every mode, release and length endings.
    task automatic directed_items();
        voice_req_t r;
        write_config(1'b1, 1'b1, 16'd8);
        for (int a = 0; a < 10; a++) begin
            r         = rand_req(MODE_LOAD);
            r.address = a;
            if (a == 0) begin
                r.sample_left  = 16'sh7FFF;
                r.sample_right = 16'sh8000;
            end else if (a == 1) begin
                r.sample_left  = 16'sh8000;
                r.sample_right = 16'sh7FFF;
            end
            queue_item(r);
        end
        // Idle voice: tick passes the mix through; release, stop and unused modes do nothing.
        r           = rand_req(MODE_TICK);
        r.mix_left  = MIX_MAX;
        r.mix_right = MIX_MIN;
        queue_tick(r);
        queue_item(rand_req(MODE_RELEASE));
        queue_item(rand_req(MODE_STOP));
        queue_item(rand_req(t_mode'(5)));
        queue_item(rand_req(t_mode'(7)));
        // Full gain, no attack, zero release step, fractional step of 1.5.
        r              = rand_req(MODE_START);
        r.phase_step   = 32'h0001_8000;
        r.velocity     = 16'h8000;
        r.attack_step  = '0;
        r.release_step = '0;
        queue_item(r);
        r           = rand_req(MODE_TICK);
        r.mix_left  = MIX_MAX;
        r.mix_right = MIX_MAX;
        queue_tick(r);
        r           = rand_req(MODE_TICK);
        r.mix_left  = MIX_MIN;
        r.mix_right = MIX_MIN;
        queue_tick(r);
        queue_item(rand_req(MODE_RELEASE));
        queue_tick(rand_req(MODE_TICK));
        // Full-scale attack, zero gain, step that runs past the length on the second tick.
        r              = rand_req(MODE_START);
        r.phase_step   = 32'h0005_0000;
        r.velocity     = '0;
        r.attack_step  = UNITY23;
        r.release_step = 24'd1;
        queue_item(r);
        queue_tick(rand_req(MODE_TICK));
        queue_tick(rand_req(MODE_TICK));
        wait_drained();
    endtask

    initial begin
        voice               = '{default: '0};
        voice.fall          = UNITY23;
        gen_voice           = voice;
        calm                = 1'b0;
        hold_arm            = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_SRC_STEREO;
        cfg_data            = '0;
        req_if.valid        = 1'b0;
        req_if.mode         = MODE_LOAD;
        req_if.address      = '0;
        req_if.sample_left  = '0;
        req_if.sample_right = '0;
        req_if.phase_step   = '0;
        req_if.velocity     = '0;
        req_if.attack_step  = '0;
        req_if.release_step = '0;
        req_if.mix_left     = '0;
        req_if.mix_right    = '0;
        rsp_if.ready        = 1'b0;
        i_rst_n             = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_items();

        // Long result stall while the sender keeps offering, so the input backs up.
        write_config(1'b1, 1'b1, 16'd65532);
        @(posedge i_clk);
        hold_arm <= 1'b1;
        @(posedge i_clk);
        hold_arm <= 1'b0;
        random_items(110);
        wait_drained();

        // Sender pauses mid-phase until every result is back.
        write_config(1'b0, 1'b1, 16'd20);
        random_items(55);
        wait_drained();
        random_items(55);
        wait_drained();

        run_phase(1'b1, 1'b0, 16'd3, 110);
        run_phase(1'b0, 1'b0, 16'd0, 80);
        run_phase(1'b1, 1'b1, 16'd1, 100);
        run_phase(1'b0, 1'b0, 16'd65532, 110);
        run_phase($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 200), 110);

        // Closing stretch at full rate on both sides.
        calm = 1'b1;
        run_phase(1'b1, 1'b1, 16'd40, 110);

        $display("Checked %0d tick results from %0d accepted transactions; %0d notes ended.",
                 results_seen, accepted_items, notes_ended);
        $display("Mono and stereo source and output, lengths 0 to 65532, stalls on both sides.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
